/* hw/rtl/oets_pkg.sv */
// shared types for the odd-even transposition sorter
// item and result payload structs, per-cell control struct
// no dependencies
package oets_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     final_element;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflow;
    } result_t;

    // per-cell control, at most one of the three is set in a cycle
    typedef struct packed {
        logic load;
        logic take_right;
        logic take_left;
    } cell_ctl_t;

endpackage

/* hw/rtl/oets_cell.sv */
// one cell of the sorting chain: holds one element and compares it
// against its right neighbor; depends on oets_pkg
module oets_cell
    import oets_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] element,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] value,
    output logic                     gt_right
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = element;
        end
        else if (ctl.take_right)
        begin
            value_next = right;
        end
        else if (ctl.take_left)
        begin
            value_next = left;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    assign gt_right = value_reg > right;

endmodule

/* hw/rtl/odd_even_transposition_sorter.sv */
// odd-even transposition sorter, top level: control and the row of cells
// depends on oets_pkg and oets_cell
//
//   port group      dir   handshake                   payload
//   item            in    item_valid / item_ready     item_t (element, final_element)
//   result          out   result_valid / result_ready result_t (sorted_value, end_of_set, overflow)
//
// loading accepts one element per cycle; item_ready is high only while loading
// sorting runs one compare-exchange phase per cycle across the filled part of the row,
// odd then even, until a round has no swap
// results leave one per cycle from cell 0 as the row shifts left; result_ready low holds it
// reset clears the counters and state; cell contents need no reset
module odd_even_transposition_sorter
    import oets_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             dropped_reg;
    logic             swapped_reg;
    logic             phase_even_reg;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]      gt;
    logic [CAPACITY-1:0]      swap;
    cell_ctl_t                ctl [CAPACITY];

    logic in_take;
    logic out_take;
    logic sorting;

    assign item_ready   = (state_reg == ST_LOAD);
    assign result_valid = (state_reg == ST_EMIT);
    assign in_take      = item_valid && item_ready;
    assign out_take     = result_valid && result_ready;
    assign sorting      = (state_reg == ST_SORT);

    assign result.sorted_value = cell_val[0];
    assign result.end_of_set   = (fill_reg == CNT_W'(1));
    assign result.overflow     = dropped_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            // pair (gi, gi+1) belongs to the odd phase when gi is odd
            localparam bit LO_ODD = (gi % 2) == 1;

            if (gi < CAPACITY - 1)
            begin : g_pair
                assign swap[gi] = sorting && gt[gi] && (LO_ODD == !phase_even_reg)
                                  && (fill_reg > CNT_W'(gi + 1));
                assign ctl[gi].take_right = swap[gi] || out_take;
            end
            else
            begin : g_last
                assign swap[gi] = 1'b0;
                assign ctl[gi].take_right = 1'b0;
            end

            if (gi > 0)
            begin : g_left
                assign ctl[gi].take_left = swap[gi-1];
            end
            else
            begin : g_first
                assign ctl[gi].take_left = 1'b0;
            end

            assign ctl[gi].load = in_take && (fill_reg == CNT_W'(gi));

            oets_cell u_cell (
                .clk      (clk),
                .ctl      (ctl[gi]),
                .element  (item.element),
                .left     (cell_val[(gi > 0) ? gi - 1 : gi]),
                .right    (cell_val[(gi < CAPACITY - 1) ? gi + 1 : gi]),
                .value    (cell_val[gi]),
                .gt_right (gt[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_reg       <= '0;
            dropped_reg    <= 1'b0;
            swapped_reg    <= 1'b0;
            phase_even_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_take)
                    begin
                        if (fill_reg < CNT_W'(CAPACITY))
                        begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (item.final_element)
                        begin
                            state_reg      <= ST_SORT;
                            swapped_reg    <= 1'b0;
                            phase_even_reg <= 1'b0;
                        end
                    end
                end
                ST_SORT:
                begin
                    if (!phase_even_reg)
                    begin
                        phase_even_reg <= 1'b1;
                        swapped_reg    <= |swap;
                    end
                    else
                    begin
                        phase_even_reg <= 1'b0;
                        swapped_reg    <= 1'b0;
                        // a round with no swap leaves the row in order
                        if (!(swapped_reg || (|swap)))
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_take)
                    begin
                        fill_reg <= fill_reg - CNT_W'(1);
                        if (fill_reg == CNT_W'(1))
                        begin
                            state_reg   <= ST_LOAD;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // emitting always has at least one and at most CAPACITY elements left
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fill_reg != '0) && (fill_reg <= CNT_W'(CAPACITY)))
        else $error("emit with empty or overfull row");

    // neighboring pairs never exchange in the same cycle
    a_swap_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (swap & (swap >> 1)) == '0)
        else $error("overlapping compare-exchange pairs");

    // last result returns the block to loading with a clean count and overflow flag
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && result.end_of_set) |=> item_ready && (fill_reg == '0) && !dropped_reg)
        else $error("set not cleared after final result");

    // exchanges only happen while sorting
    a_swap_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (swap != '0) |-> sorting)
        else $error("exchange outside sort");

endmodule

/* tb/sv/tb_odd_even_transposition_sorter.sv */
// self-checking testbench for odd_even_transposition_sorter
// predicts each sorted set from the accepted items and checks every result item
// depends on oets_pkg and the sorter rtl
`timescale 1ns / 100ps

module tb_odd_even_transposition_sorter;
    import oets_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 48;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {
        VAL_RANDOM,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_FALLING,
        VAL_RISING
    } value_mode_e;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int error_count = 0;

    // elements of the set being collected, and the sorted results still owed
    logic signed [DATA_W-1:0] open_set[$];
    logic                     open_set_dropped = 1'b0;
    result_t                  pending_results[$];

    odd_even_transposition_sorter #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // store the element, or drop it when full; a closing item yields the sorted set
    function automatic void absorb_item(input item_t it);
        logic signed [DATA_W-1:0] ordered[$];
        logic signed [DATA_W-1:0] key;
        int                       j;
        result_t                  r;
        if (open_set.size() < CAPACITY)
            open_set.push_back(it.element);
        else
            open_set_dropped = 1'b1;
        if (it.final_element)
        begin
            for (int i = 0; i < open_set.size(); i++)
            begin
                key = open_set[i];
                j = ordered.size();
                while (j > 0 && ordered[j-1] > key)
                    j--;
                ordered.insert(j, key);
            end
            for (int i = 0; i < ordered.size(); i++)
            begin
                r.sorted_value = ordered[i];
                r.end_of_set   = (i == ordered.size() - 1);
                r.overflow     = open_set_dropped;
                pending_results.push_back(r);
            end
            open_set.delete();
            open_set_dropped = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", result.sorted_value));
            else
            begin
                want = pending_results.pop_front();
                if (result.sorted_value !== want.sorted_value)
                    report_mismatch($sformatf("sorted_value %0d, want %0d",
                                              result.sorted_value, want.sorted_value));
                if (result.end_of_set !== want.end_of_set)
                    report_mismatch($sformatf("end_of_set %b, want %b at value %0d",
                                              result.end_of_set, want.end_of_set,
                                              want.sorted_value));
                if (result.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b at value %0d",
                                              result.overflow, want.overflow,
                                              want.sorted_value));
            end
        end
    end

    // called at a rising edge, returns at the edge where the item was taken
    task automatic send_item(input logic signed [DATA_W-1:0] value, input logic last);
        item_t it;
        it.element       = value;
        it.final_element = last;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        absorb_item(it);
    endtask

    // the last item is already taken, so valid drops while the results drain
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value(input value_mode_e mode);
        case (mode)
            VAL_NARROW:
                return int'($urandom_range(0, 7)) - 4;
            VAL_EXTREME:
                case ($urandom_range(4))
                    0:       return MOST_NEGATIVE;
                    1:       return MOST_POSITIVE;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    task automatic send_set(input int len, input value_mode_e mode);
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                VAL_FALLING: v = v - int'($urandom_range(1, 1000));
                VAL_RISING:  v = v + int'($urandom_range(1, 1000));
                default:     v = rand_value(mode);
            endcase
            send_item(v, i == len - 1);
        end
    endtask

    // mostly short sets, some full, some past capacity
    task automatic run_random_items(input int target);
        int sent;
        int len;
        int pick;
        value_mode_e mode;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(1, 6);
            else if (pick < 80)
                len = $urandom_range(7, CAPACITY - 1);
            else if (pick < 90)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            mode = value_mode_e'($urandom_range(VAL_RANDOM, VAL_RISING));
            send_set(len, mode);
            sent += len;
            if ($urandom_range(5) == 0)
                wait_drained();
        end
    endtask

    task automatic test_single_element();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(MOST_NEGATIVE, 1'b1);
        send_item(MOST_POSITIVE, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_item(0, 1'b0);
        send_item(MOST_POSITIVE, 1'b0);
        send_item(-1, 1'b0);
        send_item(MOST_NEGATIVE, 1'b0);
        send_item(1, 1'b0);
        send_item(MOST_POSITIVE, 1'b1);
    endtask

    // closing item arrives with the store full, so it is dropped itself
    task automatic test_overflow();
        for (int i = 0; i <= CAPACITY; i++)
            send_item(CAPACITY - 2 * i, i == CAPACITY);
    endtask

    task automatic test_drain_pause();
        idle_pct  = 0;
        stall_pct = 50;
        send_set(5, VAL_RANDOM);
        wait_drained();
        send_set(3, VAL_NARROW);
        wait_drained();
    endtask

    task automatic test_no_idling();
        idle_pct  = 0;
        stall_pct = 0;
        run_random_items(35);
    endtask

    task automatic test_sender_idle();
        idle_pct  = 80;
        stall_pct = 0;
        run_random_items(30);
    endtask

    task automatic test_receiver_stall();
        idle_pct  = 0;
        stall_pct = 80;
        run_random_items(30);
    endtask

    task automatic test_both_idle();
        idle_pct  = 11;
        stall_pct = 11;
        run_random_items(35);
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_odd_even_transposition_sorter: errors");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element();
        test_extreme_values();
        test_overflow();
        test_drain_pause();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_odd_even_transposition_sorter: clean");
        else
            $display("tb_odd_even_transposition_sorter: errors");
        $finish;
    end

endmodule

/* odd_even_transposition_sorter.f */
hw/rtl/oets_pkg.sv
hw/rtl/oets_cell.sv
hw/rtl/odd_even_transposition_sorter.sv
tb/sv/tb_odd_even_transposition_sorter.sv
